// ----- rtl/core/hufd_pkg.sv -----
// ----------------------------------------------------------------------------
// hufd_pkg
// Shared types, codes and index helpers for the tree-walk Huffman decoder.
// ----------------------------------------------------------------------------
package hufd_pkg;

  localparam int NODE_COUNT = 1024;
  localparam int ADDR_W     = $clog2(NODE_COUNT);
  localparam int INDEX_W    = 10;
  localparam int SYM_W      = 8;
  localparam int CMD_W      = 2;
  localparam int KIND_W     = 2;

  localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DECODE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

  localparam logic [KIND_W-1:0] KIND_INTERNAL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BYTE     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END      = 2'd2;

  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_ROOT_NODE = 3'd0;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [SYM_W-1:0]   symbol;
    logic [INDEX_W-1:0] zero_child;
    logic [INDEX_W-1:0] one_child;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  function automatic logic [ADDR_W-1:0] idx_to_addr(input logic [INDEX_W-1:0] idx);
    logic [31:0] wide;
    wide = {{(32-INDEX_W){1'b0}}, idx};
    return wide[ADDR_W-1:0];
  endfunction

  function automatic logic idx_in_range(input logic [INDEX_W-1:0] idx);
    logic [31:0] wide;
    wide = {{(32-INDEX_W){1'b0}}, idx};
    return wide < 32'(NODE_COUNT);
  endfunction

  function automatic logic is_leaf(input logic [KIND_W-1:0] kind);
    return (kind == KIND_BYTE) || (kind == KIND_END);
  endfunction

endpackage

// ----- rtl/core/hufd_ram.sv -----
// ----------------------------------------------------------------------------
// hufd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hufd_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/huffman_tree_walk_decoder.sv -----
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder
// Bit-serial Huffman decoder walking a code tree held in a node RAM.
//
//   channel | ports                         | moves
//   --------+-------------------------------+------------------------------
//   in      | in_valid / in_stall + fields  | one command item
//   out     | out_valid / out_stall + fields| one decoded symbol or end mark
//   cfg     | APB write/read, pready high   | root_node register
//
// Write and restart items complete while idle. A code bit inside a started
// walk reads the child node (state CHILD); the first bit of a walk reads
// the root (state FROM), then the child (state CHILD). New items stall
// until the walk is idle again. Reset clears the walk state and root; the
// node table needs no clearing pass. A held result stalls only decode items.
// ----------------------------------------------------------------------------
module huffman_tree_walk_decoder (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [hufd_pkg::CMD_W-1:0]            in_command,
  input  logic [hufd_pkg::INDEX_W-1:0]          in_node_index,
  input  logic [hufd_pkg::KIND_W-1:0]           in_node_kind,
  input  logic [hufd_pkg::SYM_W-1:0]            in_node_symbol,
  input  logic [hufd_pkg::INDEX_W-1:0]          in_zero_child,
  input  logic [hufd_pkg::INDEX_W-1:0]          in_one_child,
  input  logic                                  in_code_bit,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [hufd_pkg::SYM_W-1:0]            out_symbol,
  output logic                                  out_end_of_data,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [hufd_pkg::CFG_ADDR_W-1:0]       cfg_paddr,
  input  logic [31:0]                           cfg_pwdata,
  output logic [31:0]                           cfg_prdata,
  output logic                                  cfg_pready
);

  import hufd_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FROM  = 2'd1;
  localparam logic [1:0] ST_CHILD = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [INDEX_W-1:0] root_r, root_nxt;
  logic [INDEX_W-1:0] cur_r, cur_nxt;
  logic               started_r, started_nxt;
  logic               finished_r, finished_nxt;
  node_t              cache_r, cache_nxt;
  logic               bit_r, bit_nxt;
  logic [INDEX_W-1:0] pend_idx_r, pend_idx_nxt;
  logic               oor_r, oor_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]   out_symbol_r, out_symbol_nxt;
  logic               out_eod_r, out_eod_nxt;

  logic               accept;
  logic               wr_en;
  logic               rd_en;
  logic [INDEX_W-1:0] rd_idx;
  logic [NODE_W-1:0]  ram_rd_data;
  node_t              rd_node;
  node_t              wr_node;
  logic [INDEX_W-1:0] child_idx;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr == REG_ROOT_NODE) ? {{(32-INDEX_W){1'b0}}, root_r} : 32'd0;
  assign root_nxt   = (cfg_wr && cfg_paddr == REG_ROOT_NODE) ? cfg_pwdata[INDEX_W-1:0] : root_r;

  assign in_stall = (state_r != ST_IDLE) ||
                    (out_valid_r && out_stall && in_command == CMD_DECODE);
  assign accept   = in_valid && !in_stall;

  assign wr_node = '{kind: in_node_kind, symbol: in_node_symbol,
                     zero_child: in_zero_child, one_child: in_one_child};
  assign wr_en   = accept && in_command == CMD_WRITE && idx_in_range(in_node_index);
  assign rd_node = oor_r ? node_t'('0) : node_t'(ram_rd_data);

  hufd_ram #(
    .WIDTH(NODE_W),
    .DEPTH(NODE_COUNT)
  ) u_node_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx_to_addr(in_node_index)),
    .wr_data (wr_node),
    .rd_en   (rd_en),
    .rd_addr (idx_to_addr(rd_idx)),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    started_nxt    = started_r;
    finished_nxt   = finished_r;
    cache_nxt      = cache_r;
    bit_nxt        = bit_r;
    pend_idx_nxt   = pend_idx_r;
    oor_nxt        = oor_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_symbol_nxt = out_symbol_r;
    out_eod_nxt    = out_eod_r;
    rd_en          = 1'b0;
    rd_idx         = root_r;
    child_idx      = cache_r.zero_child;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_command)
            CMD_WRITE: begin
              if (started_r && wr_en && in_node_index == cur_r) begin
                cache_nxt = wr_node;
              end
            end
            CMD_RESTART: begin
              started_nxt  = 1'b0;
              finished_nxt = 1'b0;
            end
            CMD_DECODE: begin
              if (!finished_r) begin
                bit_nxt = in_code_bit;
                if (!started_r) begin
                  rd_en     = 1'b1;
                  rd_idx    = root_r;
                  oor_nxt   = !idx_in_range(root_r);
                  state_nxt = ST_FROM;
                end else if (is_leaf(cache_r.kind)) begin
                  finished_nxt   = 1'b1;
                  started_nxt    = 1'b0;
                  out_valid_nxt  = 1'b1;
                  out_symbol_nxt = '0;
                  out_eod_nxt    = 1'b1;
                end else begin
                  child_idx    = in_code_bit ? cache_r.one_child : cache_r.zero_child;
                  rd_en        = 1'b1;
                  rd_idx       = child_idx;
                  oor_nxt      = !idx_in_range(child_idx);
                  pend_idx_nxt = child_idx;
                  state_nxt    = ST_CHILD;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_FROM: begin
        if (is_leaf(rd_node.kind)) begin
          finished_nxt   = 1'b1;
          started_nxt    = 1'b0;
          out_valid_nxt  = 1'b1;
          out_symbol_nxt = '0;
          out_eod_nxt    = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          child_idx    = bit_r ? rd_node.one_child : rd_node.zero_child;
          rd_en        = 1'b1;
          rd_idx       = child_idx;
          oor_nxt      = !idx_in_range(child_idx);
          pend_idx_nxt = child_idx;
          state_nxt    = ST_CHILD;
        end
      end
      ST_CHILD: begin
        cur_nxt   = pend_idx_r;
        state_nxt = ST_IDLE;
        case (rd_node.kind)
          KIND_BYTE: begin
            started_nxt    = 1'b0;
            out_valid_nxt  = 1'b1;
            out_symbol_nxt = rd_node.symbol;
            out_eod_nxt    = 1'b0;
          end
          KIND_END: begin
            finished_nxt   = 1'b1;
            started_nxt    = 1'b0;
            out_valid_nxt  = 1'b1;
            out_symbol_nxt = '0;
            out_eod_nxt    = 1'b1;
          end
          default: begin
            started_nxt = 1'b1;
            cache_nxt   = rd_node;
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      root_r      <= '0;
      cur_r       <= '0;
      started_r   <= 1'b0;
      finished_r  <= 1'b0;
      out_valid_r <= 1'b0;
      oor_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      root_r      <= root_nxt;
      cur_r       <= cur_nxt;
      started_r   <= started_nxt;
      finished_r  <= finished_nxt;
      out_valid_r <= out_valid_nxt;
      oor_r       <= oor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cache_r      <= cache_nxt;
    bit_r        <= bit_nxt;
    pend_idx_r   <= pend_idx_nxt;
    out_symbol_r <= out_symbol_nxt;
    out_eod_r    <= out_eod_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_symbol      = out_symbol_r;
  assign out_end_of_data = out_eod_r;

endmodule

// ----- sim/huffman_tree_walk_decoder_tb.sv -----
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder_tb
// Self-checking bench for the tree-walk Huffman decoder. Node writes,
// code bits and restarts go in on the input channel. A local tree-walk
// predictor computes the decoded bytes and end marks, which are compared in
// order with the result channel. A directed walk comes first, then root
// register settings, then random trees decoded with random code bits under
// random idling, a long output hold-off and a mid-run drain.
// ----------------------------------------------------------------------------
module huffman_tree_walk_decoder_tb;
  import hufd_pkg::*;

  localparam logic [CMD_W-1:0]  CMD_NONE   = 2'd3;
  localparam logic [KIND_W-1:0] KIND_THREE = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 118;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [INDEX_W-1:0] node_index;
    logic [KIND_W-1:0]  node_kind;
    logic [SYM_W-1:0]   node_symbol;
    logic [INDEX_W-1:0] zero_child;
    logic [INDEX_W-1:0] one_child;
    logic               code_bit;
  } cmd_item_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             end_of_data;
  } decoded_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [CMD_W-1:0]    in_command = CMD_NONE;
  logic [INDEX_W-1:0]  in_node_index = '0;
  logic [KIND_W-1:0]   in_node_kind = '0;
  logic [SYM_W-1:0]    in_node_symbol = '0;
  logic [INDEX_W-1:0]  in_zero_child = '0;
  logic [INDEX_W-1:0]  in_one_child = '0;
  logic                in_code_bit = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [SYM_W-1:0]    out_symbol;
  logic                out_end_of_data;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0]         cfg_pwdata = '0;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  // predictor state
  node_t              tree_mem [NODE_COUNT];
  bit                 tree_written [NODE_COUNT];
  logic [INDEX_W-1:0] walk_node = '0;
  logic [INDEX_W-1:0] root_idx = '0;
  bit                 walk_on = 1'b0;
  bit                 walk_done = 1'b0;
  decoded_t           expected_symbols [$];

  int unsigned gap_pct = 23;
  int unsigned stall_pct = 23;
  int          hold_ticket = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          mismatches = 0;
  int          cycles = 0;
  int          pool [$];
  decoded_t    want;

  huffman_tree_walk_decoder uut (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[huffman_tree_walk_decoder] ERROR");
      $finish;
    end
  end

  // receiver: random stall, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_ticket != hold_seen) begin
      hold_seen <= hold_ticket;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_symbols.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: symbol %02h end %0b", out_symbol, out_end_of_data);
      end else begin
        want = expected_symbols.pop_front();
        if (want.symbol !== out_symbol || want.end_of_data !== out_end_of_data) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected symbol %02h end %0b, got symbol %02h end %0b",
                     want.symbol, want.end_of_data, out_symbol, out_end_of_data);
        end
      end
    end
  end

  // Tree-walk predictor. Returns 0 for items the decoder ignores.
  function automatic bit walk_tree(input cmd_item_t it);
    logic [INDEX_W-1:0] from_i;
    logic [INDEX_W-1:0] next_i;
    node_t              from_n;
    node_t              next_n;
    case (it.command)
      CMD_WRITE: begin
        tree_mem[it.node_index] = {it.node_kind, it.node_symbol, it.zero_child, it.one_child};
        tree_written[it.node_index] = 1'b1;
        return 1'b1;
      end
      CMD_RESTART: begin
        walk_on = 1'b0;
        walk_done = 1'b0;
        return 1'b1;
      end
      CMD_DECODE: begin
        if (walk_done)
          return 1'b0;
        from_i = walk_on ? walk_node : root_idx;
        from_n = tree_mem[from_i];
        if (from_n.kind == KIND_BYTE || from_n.kind == KIND_END) begin
          // walk starts on a leaf: end mark
          walk_done = 1'b1;
          walk_on = 1'b0;
          expected_symbols.push_back(decoded_t'{symbol: '0, end_of_data: 1'b1});
          return 1'b1;
        end
        next_i = it.code_bit ? from_n.one_child : from_n.zero_child;
        next_n = tree_mem[next_i];
        walk_node = next_i;
        if (next_n.kind == KIND_BYTE) begin
          walk_on = 1'b0;
          expected_symbols.push_back(decoded_t'{symbol: next_n.symbol, end_of_data: 1'b0});
        end else if (next_n.kind == KIND_END) begin
          walk_done = 1'b1;
          walk_on = 1'b0;
          expected_symbols.push_back(decoded_t'{symbol: '0, end_of_data: 1'b1});
        end else begin
          walk_on = 1'b1;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic cmd_item_t mk(input logic [CMD_W-1:0] cmd, input int idx,
                                   input logic [KIND_W-1:0] kind, input logic [SYM_W-1:0] sym,
                                   input int zc, input int oc, input logic cb);
    cmd_item_t it;
    it.command = cmd;
    it.node_index = idx[INDEX_W-1:0];
    it.node_kind = kind;
    it.node_symbol = sym;
    it.zero_child = zc[INDEX_W-1:0];
    it.one_child = oc[INDEX_W-1:0];
    it.code_bit = cb;
    return it;
  endfunction

  function automatic cmd_item_t rand_fields(input logic [CMD_W-1:0] cmd);
    return mk(cmd, $urandom_range(1023), KIND_W'($urandom_range(3)),
              SYM_W'($urandom_range(255)), $urandom_range(1023), $urandom_range(1023),
              1'($urandom_range(1)));
  endfunction

  // tree node with children taken from the current pool
  function automatic cmd_item_t rand_node(input int idx);
    cmd_item_t   it;
    int unsigned r;
    it = rand_fields(CMD_WRITE);
    it.node_index = idx[INDEX_W-1:0];
    r = $urandom_range(99);
    it.node_kind = (r < 40) ? KIND_INTERNAL : (r < 75) ? KIND_BYTE :
                   (r < 88) ? KIND_END : KIND_THREE;
    it.zero_child = INDEX_W'(pool[$urandom_range(pool.size() - 1)]);
    it.one_child = INDEX_W'(pool[$urandom_range(pool.size() - 1)]);
    return it;
  endfunction

  // a code bit that would read a never-written node writes that node instead
  function automatic cmd_item_t make_safe(input cmd_item_t it);
    logic [INDEX_W-1:0] from_i;
    logic [INDEX_W-1:0] next_i;
    cmd_item_t          fix;
    if (it.command != CMD_DECODE || walk_done)
      return it;
    from_i = walk_on ? walk_node : root_idx;
    fix = rand_fields(CMD_WRITE);
    fix.node_kind = KIND_BYTE;
    if (!tree_written[from_i]) begin
      fix.node_index = from_i;
      return fix;
    end
    if (tree_mem[from_i].kind == KIND_BYTE || tree_mem[from_i].kind == KIND_END)
      return it;
    next_i = it.code_bit ? tree_mem[from_i].one_child : tree_mem[from_i].zero_child;
    if (!tree_written[next_i]) begin
      fix.node_index = next_i;
      return fix;
    end
    return it;
  endfunction

  task automatic send_cmd(input cmd_item_t it, output bit acted);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= it.command;
    in_node_index <= it.node_index;
    in_node_kind <= it.node_kind;
    in_node_symbol <= it.node_symbol;
    in_zero_child <= it.zero_child;
    in_one_child <= it.one_child;
    in_code_bit <= it.code_bit;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    acted = walk_tree(it);
  endtask

  task automatic send(input cmd_item_t it);
    bit acted;
    send_cmd(it, acted);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_symbols.size() != 0)
      @(posedge clk);
  endtask

  task automatic settle();
    wait_drained();
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready)
      @(posedge clk);
    if (addr == REG_ROOT_NODE)
      root_idx = data[INDEX_W-1:0];
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready)
      @(posedge clk);
    if (cfg_prdata[INDEX_W-1:0] !== data[INDEX_W-1:0]) begin
      mismatches++;
      if (mismatches <= 10)
        $display("root readback: expected %0d, got %0d", data[INDEX_W-1:0],
                 cfg_prdata[INDEX_W-1:0]);
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic test_directed_walk();
    send(mk(CMD_WRITE, 0, KIND_INTERNAL, 8'h00, 1, 1023, 1'b0));
    send(mk(CMD_WRITE, 1, KIND_BYTE, 8'hFF, 1023, 1023, 1'b1));
    send(mk(CMD_WRITE, 1023, KIND_THREE, 8'hAA, 2, 3, 1'b0));
    send(mk(CMD_WRITE, 2, KIND_BYTE, 8'h00, 0, 0, 1'b0));
    send(mk(CMD_WRITE, 3, KIND_END, 8'h55, 0, 0, 1'b1));
    send(mk(CMD_DECODE, 0, KIND_INTERNAL, 8'h00, 0, 0, 1'b0));
    send(mk(CMD_DECODE, 1023, KIND_THREE, 8'hFF, 1023, 1023, 1'b1));
    send(mk(CMD_DECODE, 0, KIND_INTERNAL, 8'h00, 0, 0, 1'b0));
    send(mk(CMD_DECODE, 0, KIND_INTERNAL, 8'h00, 0, 0, 1'b1));
    send(mk(CMD_DECODE, 0, KIND_INTERNAL, 8'h00, 0, 0, 1'b1));
    // bits after the end mark
    send(mk(CMD_DECODE, 0, KIND_INTERNAL, 8'h00, 0, 0, 1'b0));
    send(mk(CMD_DECODE, 0, KIND_INTERNAL, 8'h00, 0, 0, 1'b1));
    send(mk(CMD_NONE, 1023, KIND_THREE, 8'hFF, 1023, 1023, 1'b1));
    send(mk(CMD_RESTART, 0, KIND_INTERNAL, 8'h00, 0, 0, 1'b0));
    send(mk(CMD_DECODE, 0, KIND_INTERNAL, 8'h00, 0, 0, 1'b1));
    // node under the walk turned into a leaf
    send(mk(CMD_WRITE, 1023, KIND_BYTE, 8'h3C, 0, 0, 1'b0));
    send(mk(CMD_DECODE, 0, KIND_INTERNAL, 8'h00, 0, 0, 1'b0));
    send(mk(CMD_RESTART, 0, KIND_INTERNAL, 8'h00, 0, 0, 1'b0));
    send(mk(CMD_WRITE, 1023, KIND_THREE, 8'hAA, 2, 3, 1'b0));
    send(mk(CMD_DECODE, 0, KIND_INTERNAL, 8'h00, 0, 0, 1'b0));
  endtask

  task automatic test_root_config();
    settle();
    cfg_write(REG_ROOT_NODE, 32'd1023);
    send(mk(CMD_RESTART, 0, KIND_INTERNAL, 8'h00, 0, 0, 1'b0));
    send(mk(CMD_DECODE, 0, KIND_INTERNAL, 8'h00, 0, 0, 1'b0));
    send(mk(CMD_DECODE, 0, KIND_INTERNAL, 8'h00, 0, 0, 1'b1));
    settle();
    // root that is itself a leaf
    cfg_write(REG_ROOT_NODE, 32'd2);
    send(mk(CMD_RESTART, 0, KIND_INTERNAL, 8'h00, 0, 0, 1'b0));
    send(mk(CMD_DECODE, 0, KIND_INTERNAL, 8'h00, 0, 0, 1'b1));
    send(mk(CMD_RESTART, 0, KIND_INTERNAL, 8'h00, 0, 0, 1'b0));
    settle();
    cfg_write(REG_ROOT_NODE, 32'd0);
  endtask

  task automatic test_random_trees();
    cmd_item_t   it;
    bit          acted;
    int          done_here;
    int unsigned r;
    int          root;
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      gap_pct = (ph == 3) ? 0 : 23;
      stall_pct = (ph == 3) ? 0 : 23;
      root = (ph == 1) ? 1023 : (ph == 2) ? 0 : $urandom_range(1023);
      pool.delete();
      pool.push_back(root);
      repeat ($urandom_range(3, 15)) pool.push_back($urandom_range(1023));
      cfg_write(REG_ROOT_NODE, root);
      send(mk(CMD_RESTART, 0, KIND_INTERNAL, 8'h00, 0, 0, 1'b0));
      foreach (pool[i])
        send(rand_node(pool[i]));
      if (ph == 5)
        hold_ticket <= hold_ticket + 1;
      done_here = 0;
      while (done_here < PHASE_ITEMS) begin
        r = $urandom_range(99);
        it = rand_fields(CMD_DECODE);
        if ((walk_done && r < 50) || (r >= 72 && r < 78))
          it.command = CMD_RESTART;
        else if (r >= 78 && r < 88)
          it = rand_node(pool[$urandom_range(pool.size() - 1)]);
        else if (r >= 88 && r < 93)
          it.command = CMD_WRITE;
        else if (r >= 93)
          it.command = CMD_NONE;
        it = make_safe(it);
        send_cmd(it, acted);
        if (acted) begin
          done_here++;
          if (ph == 7 && done_here == PHASE_ITEMS / 2)
            wait_drained();
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_walk();
    test_root_config();
    test_random_trees();
    wait_drained();
    repeat (20) @(posedge clk);
    if (expected_symbols.size() != 0)
      mismatches++;
    if (mismatches == 0) begin
      $display("[huffman_tree_walk_decoder] OK");
    end else begin
      $display("[huffman_tree_walk_decoder] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/hufd_pkg.sv
rtl/core/hufd_ram.sv
rtl/core/huffman_tree_walk_decoder.sv
sim/huffman_tree_walk_decoder_tb.sv
